/* design/sem_pkg.sv */
// Shared types, constants and arithmetic helpers of the Scharr edge magnitude unit.
package sem_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int PIXEL_BITS  = 8;
  localparam int COL_BITS    = $clog2(MAX_WIDTH);
  localparam int ROW_BITS    = 12;
  localparam int GRAD_BITS   = 14;
  localparam int ABS_BITS    = GRAD_BITS - 1;
  localparam int SQ_BITS     = 2 * ABS_BITS;
  localparam int SUM_BITS    = SQ_BITS + 1;
  localparam int MAG_BITS    = 8;
  localparam int ROOT_BITS   = 2 * MAG_BITS;
  localparam int ROOT_STEPS  = MAG_BITS;
  localparam int STEP_BITS   = $clog2(ROOT_STEPS);
  // Sums above this round to 256 or more and saturate
  localparam int SAT_LIMIT   = 65280;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int WIDTH_BITS  = 11;
  localparam int HEIGHT_BITS = 12;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = WIDTH_BITS'(1024);
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = HEIGHT_BITS'(480);
  localparam logic [MAG_BITS-1:0]    THRESH_RESET = MAG_BITS'(255);

  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_IMAGE_WIDTH    = 2'd0;
  localparam cfg_idx_t CFG_IMAGE_HEIGHT   = 2'd1;
  localparam cfg_idx_t CFG_EDGE_THRESHOLD = 2'd2;

  typedef logic [PIXEL_BITS-1:0] pix_t;
  typedef logic signed [GRAD_BITS-1:0] grad_t;

  // One pending output: both gradients and where it sits in the frame
  typedef struct packed {
    grad_t               gx;
    grad_t               gy;
    logic [ROW_BITS-1:0] row;
    logic [COL_BITS-1:0] col;
    logic                fend;
  } job_t;

  // Last column and last row index after clamping the size registers
  typedef struct packed {
    logic [COL_BITS-1:0] last_col;
    logic [ROW_BITS-1:0] last_row;
  } frame_lim_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_LOAD,
    FE_EMIT
  } fe_state_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_ADD,
    BK_ROOT,
    BK_OUT
  } bk_state_t;

  // 3*(pa-ma) + 10*(pb-mb) + 3*(pc-mc)
  function automatic grad_t scharr_diff(input pix_t pa, input pix_t pb, input pix_t pc,
                                        input pix_t ma, input pix_t mb, input pix_t mc);
    grad_t da;
    grad_t db;
    grad_t dc;
    da = $signed(GRAD_BITS'(pa)) - $signed(GRAD_BITS'(ma));
    db = $signed(GRAD_BITS'(pb)) - $signed(GRAD_BITS'(mb));
    dc = $signed(GRAD_BITS'(pc)) - $signed(GRAD_BITS'(mc));
    return da * 14'sd3 + db * 14'sd10 + dc * 14'sd3;
  endfunction

endpackage

/* design/sem_front.sv */
// Front end: line stores, 3x3 window, border mirroring and gradient jobs.
module sem_front (
  input  logic                clk,
  input  logic                rst,
  input  sem_pkg::pix_t       pixel,
  input  logic                pixel_valid,
  output logic                pixel_stall,
  input  sem_pkg::frame_lim_t lim,
  input  sem_pkg::q_stat_t    q_stat,
  output logic                push,
  output sem_pkg::job_t       push_job
);
  import sem_pkg::*;

  fe_state_t state;
  fe_state_t state_next;

  logic [COL_BITS-1:0] col_count;
  logic [ROW_BITS-1:0] row_count;
  pix_t                pix_hold;
  logic [COL_BITS-1:0] c_hold;
  logic [ROW_BITS-1:0] r_hold;
  logic                lc_hold;
  logic                lr_hold;
  pix_t                rd_a;
  pix_t                rd_b;
  pix_t                line_a [MAX_WIDTH];
  pix_t                line_b [MAX_WIDTH];
  pix_t                win    [9];
  logic [3:0]          pend;
  logic [3:0]          mask;
  logic [1:0]          sel;
  logic [3:0]          sel_oh;
  logic [3:0]          pend_next;
  logic                accept;
  logic                last_col_now;
  logic                last_row_now;
  logic                lower;
  logic                last;
  pix_t                cols [3][3];
  pix_t                lf   [3];
  pix_t                md   [3];
  pix_t                rt   [3];

  assign accept       = pixel_valid && (state == FE_IDLE);
  assign last_col_now = col_count >= lim.last_col;
  assign last_row_now = row_count >= lim.last_row;

  // Outputs due for the pixel just loaded: upper row first, then the mirrored last row
  assign mask[0] = (r_hold != '0) && (c_hold != '0);
  assign mask[1] = (r_hold != '0) && lc_hold;
  assign mask[2] = (r_hold != '0) && lr_hold && (c_hold != '0);
  assign mask[3] = (r_hold != '0) && lr_hold && lc_hold;

  // Pick the lowest pending output
  always_comb begin
    if (pend[0]) begin
      sel = 2'd0;
    end else if (pend[1]) begin
      sel = 2'd1;
    end else if (pend[2]) begin
      sel = 2'd2;
    end else begin
      sel = 2'd3;
    end
    sel_oh    = 4'b0001 << sel;
    pend_next = pend & ~sel_oh;
  end

  // Form the window columns for the selected output and its gradients
  always_comb begin
    lower = sel[1];
    last  = sel[0];
    for (int k = 0; k < 3; k++) begin
      if (lower) begin
        cols[k][0] = win[3*k+1];
        cols[k][1] = win[3*k+2];
        cols[k][2] = win[3*k+1];
      end else begin
        cols[k][0] = win[3*k];
        cols[k][1] = win[3*k+1];
        cols[k][2] = win[3*k+2];
      end
    end
    for (int j = 0; j < 3; j++) begin
      if (last) begin
        lf[j] = cols[1][j];
        md[j] = cols[2][j];
        rt[j] = cols[1][j];
      end else begin
        lf[j] = (c_hold == COL_BITS'(1)) ? cols[2][j] : cols[0][j];
        md[j] = cols[1][j];
        rt[j] = cols[2][j];
      end
    end
    push_job.gx   = scharr_diff(rt[0], rt[1], rt[2], lf[0], lf[1], lf[2]);
    push_job.gy   = scharr_diff(lf[2], md[2], rt[2], lf[0], md[0], rt[0]);
    push_job.row  = lower ? r_hold : r_hold - ROW_BITS'(1);
    push_job.col  = last ? c_hold : c_hold - COL_BITS'(1);
    push_job.fend = lower && last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FE_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake
  always_comb begin
    state_next  = state;
    pixel_stall = 1'b1;
    push        = 1'b0;
    case (state)
      FE_IDLE: begin
        pixel_stall = 1'b0;
        if (pixel_valid) begin
          state_next = FE_LOAD;
        end
      end
      FE_LOAD: begin
        state_next = (mask != '0) ? FE_EMIT : FE_IDLE;
      end
      FE_EMIT: begin
        push = !q_stat.full;
        if (!q_stat.full && (pend_next == '0)) begin
          state_next = FE_IDLE;
        end
      end
      default: begin
        state_next = FE_IDLE;
      end
    endcase
  end

  // Advance position counters and pending outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      pend      <= '0;
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else begin
      if (accept) begin
        if (last_col_now) begin
          col_count <= '0;
          row_count <= last_row_now ? '0 : row_count + ROW_BITS'(1);
        end else begin
          col_count <= col_count + COL_BITS'(1);
        end
      end
      if (state == FE_LOAD) begin
        pend <= mask;
        for (int i = 0; i < 6; i++) begin
          win[i] <= win[i+3];
        end
        win[6] <= (r_hold >= ROW_BITS'(2)) ? rd_a : pix_hold;
        win[7] <= rd_b;
        win[8] <= pix_hold;
      end else if (push) begin
        pend <= pend_next;
      end
    end
  end

  // Hold the accepted pixel and its position
  always_ff @(posedge clk) begin
    if (accept) begin
      pix_hold <= pixel;
      c_hold   <= col_count;
      r_hold   <= row_count;
      lc_hold  <= last_col_now;
      lr_hold  <= last_row_now;
    end
  end

  // Line stores: read on accept, shift the column down one row on load
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_a <= line_a[col_count];
      rd_b <= line_b[col_count];
    end
    if (state == FE_LOAD) begin
      line_a[c_hold] <= rd_b;
      line_b[c_hold] <= pix_hold;
    end
  end

endmodule

/* design/sem_queue.sv */
// Short job queue between the front end and the magnitude back end.
module sem_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sem_pkg::job_t    push_job,
  input  logic             pop,
  output sem_pkg::job_t    pop_job,
  output sem_pkg::q_stat_t q_stat
);
  import sem_pkg::*;

  job_t                 entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;

  assign q_stat.empty = (count == '0);
  assign q_stat.full  = (count == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign pop_job      = entries[rd_ptr];

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + (QPTR_BITS+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPTR_BITS+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

/* design/sem_back.sv */
// Back end: squares, bit-serial square root, rounding, threshold and output register.
module sem_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  sem_pkg::job_t                        pop_job,
  input  sem_pkg::q_stat_t                     q_stat,
  output logic                                 pop,
  input  logic [sem_pkg::MAG_BITS-1:0]         edge_threshold,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic signed [sem_pkg::GRAD_BITS-1:0] gradient_x,
  output logic signed [sem_pkg::GRAD_BITS-1:0] gradient_y,
  output logic [sem_pkg::MAG_BITS-1:0]         magnitude,
  output logic                                 edge_flag,
  output logic [sem_pkg::ROW_BITS-1:0]         out_row,
  output logic [sem_pkg::COL_BITS-1:0]         out_col,
  output logic                                 frame_end
);
  import sem_pkg::*;

  bk_state_t state;
  bk_state_t state_next;

  job_t                  job;
  logic [ABS_BITS-1:0]   ax;
  logic [ABS_BITS-1:0]   ay;
  logic [SQ_BITS-1:0]    sqx;
  logic [SQ_BITS-1:0]    sqy;
  logic [SUM_BITS-1:0]   sum;
  logic                  sat;
  logic [ROOT_BITS-1:0]  rem;
  logic [ROOT_BITS-1:0]  res;
  logic [ROOT_BITS-1:0]  root_bit;
  logic [STEP_BITS-1:0]  step;
  logic [ROOT_BITS:0]    trial;
  logic                  take;
  logic                  round_up;
  logic [MAG_BITS-1:0]   mag;
  logic                  out_free;
  logic                  load_out;

  assign ax       = ABS_BITS'(job.gx[GRAD_BITS-1] ? -job.gx : job.gx);
  assign ay       = ABS_BITS'(job.gy[GRAD_BITS-1] ? -job.gy : job.gy);
  assign sum      = SUM_BITS'(sqx) + SUM_BITS'(sqy);
  assign trial    = (ROOT_BITS+1)'(res) + (ROOT_BITS+1)'(root_bit);
  assign take     = (ROOT_BITS+1)'(rem) >= trial;
  assign round_up = rem > res;
  assign mag      = sat ? {MAG_BITS{1'b1}} : res[MAG_BITS-1:0] + MAG_BITS'(round_up);
  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, queue pop and output load
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load_out   = 1'b0;
    case (state)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          pop        = 1'b1;
          state_next = BK_MUL;
        end
      end
      BK_MUL: begin
        state_next = BK_ADD;
      end
      BK_ADD: begin
        state_next = (sum > SUM_BITS'(SAT_LIMIT)) ? BK_OUT : BK_ROOT;
      end
      BK_ROOT: begin
        if (step == STEP_BITS'(ROOT_STEPS - 1)) begin
          state_next = BK_OUT;
        end
      end
      BK_OUT: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // Datapath: one square root bit per cycle
  always_ff @(posedge clk) begin
    if (pop) begin
      job <= pop_job;
    end
    if (state == BK_MUL) begin
      sqx <= ax * ax;
      sqy <= ay * ay;
    end
    if (state == BK_ADD) begin
      sat      <= sum > SUM_BITS'(SAT_LIMIT);
      rem      <= sum[ROOT_BITS-1:0];
      res      <= '0;
      root_bit <= ROOT_BITS'(1) << (ROOT_BITS - 2);
      step     <= '0;
    end
    if (state == BK_ROOT) begin
      if (take) begin
        rem <= rem - trial[ROOT_BITS-1:0];
        res <= (res >> 1) + root_bit;
      end else begin
        res <= res >> 1;
      end
      root_bit <= root_bit >> 2;
      step     <= step + STEP_BITS'(1);
    end
  end

  // Output register: set on load, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      gradient_x <= job.gx;
      gradient_y <= job.gy;
      magnitude  <= mag;
      edge_flag  <= mag > edge_threshold;
      out_row    <= job.row;
      out_col    <= job.col;
      frame_end  <= job.fend;
    end
  end

endmodule

/* design/scharr_edge_magnitude_threshold_unit.sv */
// Scharr 3x3 edge magnitude and threshold unit, top level.
// Front end takes a new pixel only once the outputs it queues for the last one (0 to 4) are in.
// The back end handles one output at a time: squares, sum, then the 8-step bit-serial
// square root (skipped when saturated); a 4-entry queue lets the front run ahead of it.
// Synchronous reset clears counters, queue and output valid and sets the config registers
// to their reset values; line stores hold.
module scharr_edge_magnitude_threshold_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 pixel_valid,
  output logic                                 pixel_stall,
  input  logic [sem_pkg::PIXEL_BITS-1:0]       pixel,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic signed [sem_pkg::GRAD_BITS-1:0] gradient_x,
  output logic signed [sem_pkg::GRAD_BITS-1:0] gradient_y,
  output logic [sem_pkg::MAG_BITS-1:0]         magnitude,
  output logic                                 edge_flag,
  output logic [sem_pkg::ROW_BITS-1:0]         out_row,
  output logic [sem_pkg::COL_BITS-1:0]         out_col,
  output logic                                 frame_end,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [sem_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [31:0]                          cfg_data
);
  import sem_pkg::*;

  logic [WIDTH_BITS-1:0]  image_width;
  logic [HEIGHT_BITS-1:0] image_height;
  logic [MAG_BITS-1:0]    edge_threshold;
  frame_lim_t             lim;
  q_stat_t                q_stat;
  logic                   push;
  logic                   pop;
  job_t                   push_job;
  job_t                   pop_job;

  assign cfg_ready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= WIDTH_RESET;
      image_height   <= HEIGHT_RESET;
      edge_threshold <= THRESH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:    image_width    <= cfg_data[WIDTH_BITS-1:0];
        CFG_IMAGE_HEIGHT:   image_height   <= cfg_data[HEIGHT_BITS-1:0];
        CFG_EDGE_THRESHOLD: edge_threshold <= cfg_data[MAG_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Clamp frame size to the supported range
  always_comb begin
    if (image_width < WIDTH_BITS'(2)) begin
      lim.last_col = COL_BITS'(1);
    end else if (image_width > WIDTH_BITS'(MAX_WIDTH)) begin
      lim.last_col = COL_BITS'(MAX_WIDTH - 1);
    end else begin
      lim.last_col = COL_BITS'(image_width - WIDTH_BITS'(1));
    end
    if (image_height < HEIGHT_BITS'(2)) begin
      lim.last_row = ROW_BITS'(1);
    end else begin
      lim.last_row = ROW_BITS'(image_height - HEIGHT_BITS'(1));
    end
  end

  sem_front u_front (
    .clk         (clk),
    .rst         (rst),
    .pixel       (pixel),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .lim         (lim),
    .q_stat      (q_stat),
    .push        (push),
    .push_job    (push_job)
  );

  sem_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .q_stat   (q_stat)
  );

  sem_back u_back (
    .clk            (clk),
    .rst            (rst),
    .pop_job        (pop_job),
    .q_stat         (q_stat),
    .pop            (pop),
    .edge_threshold (edge_threshold),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .gradient_x     (gradient_x),
    .gradient_y     (gradient_y),
    .magnitude      (magnitude),
    .edge_flag      (edge_flag),
    .out_row        (out_row),
    .out_col        (out_col),
    .frame_end      (frame_end)
  );

endmodule

/* design/sem_checker.sv */
// Port-level checks for the Scharr edge magnitude unit, bound to the top level.
module sem_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 result_valid,
  input logic                                 result_stall,
  input logic signed [sem_pkg::GRAD_BITS-1:0] gradient_x,
  input logic signed [sem_pkg::GRAD_BITS-1:0] gradient_y,
  input logic [sem_pkg::MAG_BITS-1:0]         magnitude,
  input logic                                 edge_flag,
  input logic [sem_pkg::ROW_BITS-1:0]         out_row,
  input logic [sem_pkg::COL_BITS-1:0]         out_col,
  input logic                                 frame_end
);
  import sem_pkg::*;

  // No item offered right after reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result_valid set after reset");

  // Stalled item holds
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(gradient_x) &&
    $stable(gradient_y) && $stable(magnitude) && $stable(out_row) && $stable(out_col) &&
    $stable(frame_end))
    else $error("stalled result changed");

  // Edge flag needs a nonzero magnitude
  a_edge_mag: assert property (@(posedge clk) disable iff (rst)
    result_valid && edge_flag |-> magnitude != '0)
    else $error("edge flag with zero magnitude");

  // Flat window gives zero magnitude
  a_flat_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && gradient_x == '0 && gradient_y == '0 |-> magnitude == '0)
    else $error("nonzero magnitude for zero gradients");

  // Frame end falls on the last column, never column zero
  a_fend_col: assert property (@(posedge clk) disable iff (rst)
    result_valid && frame_end |-> out_col != '0)
    else $error("frame end on column zero");

endmodule

bind scharr_edge_magnitude_threshold_unit sem_checker u_sem_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .gradient_x   (gradient_x),
  .gradient_y   (gradient_y),
  .magnitude    (magnitude),
  .edge_flag    (edge_flag),
  .out_row      (out_row),
  .out_col      (out_col),
  .frame_end    (frame_end)
);
